// ===== sv/bcm_pkg.sv =====
// Shared types and constants for the banked cartridge mapper.
// No dependencies; imported by every module of the block.
package bcm_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [15:0] AddrMask   = 16'hF003;
  localparam logic [15:0] AddrMirror = 16'h8001;
  localparam logic [15:0] AddrCmd    = 16'hA000;
  localparam logic [15:0] AddrData   = 16'hC000;
  localparam logic [15:0] AddrIrq    = 16'hE003;
  localparam logic [7:0]  EvenMask   = 8'hFE;
  localparam logic [7:0]  CmdMask    = 8'h07;
  localparam logic [7:0]  LowBit     = 8'h01;
  localparam logic [7:0]  PrgReset   = 8'd2;

  // Last step of the init sequence: 4 program slots then 8 character slots.
  localparam logic [3:0]  InitLastStep = 4'd11;
  localparam logic [3:0]  InitChrStart = 4'd4;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_INIT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CHR    = 2'd1,
    KIND_PRG    = 2'd2,
    KIND_MIRROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CMD_CHR01 = 3'd0,
    CMD_CHR5  = 3'd1,
    CMD_CHR23 = 3'd2,
    CMD_CHR7  = 3'd3,
    CMD_PRG0  = 3'd4,
    CMD_PRG1  = 3'd5,
    CMD_CHR4  = 3'd6,
    CMD_CHR6  = 3'd7
  } cmd_t;

  // How the back end expands one queued request into results.
  typedef enum logic [1:0] {
    OP_ONE  = 2'd0,  // single result
    OP_PAIR = 2'd1,  // slot/bank, then slot+1/bank+1
    OP_INIT = 2'd2   // twelve default mappings, bank holds last program bank
  } op_t;

  typedef struct packed {
    op_t        op;
    kind_t      kind;
    logic [2:0] slot;
    logic [7:0] bank;
    logic       pulse;
  } req_t;

endpackage

// ===== sv/bcm_front.sv =====
// Front end: accepts input requests, keeps mapper state and the size register,
// and turns each request into at most one queue entry. Depends on bcm_pkg.
module bcm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_address,
  input  logic [7:0]         in_value,
  input  logic               in_vblank,
  input  logic               q_full,
  output logic               in_ready,
  output logic               q_push,
  output bcm_pkg::req_t      q_req
);
  import bcm_pkg::*;

  logic [7:0] prg_banks_r;
  logic [2:0] cmd_idx_r, cmd_idx_nxt;
  logic       armed_r, armed_nxt;
  logic [7:0] line_cnt_r, line_cnt_nxt;
  logic       accept;
  logic       emit;
  logic [15:0] dec_addr;
  logic [7:0] even;
  logic [7:0] dec_cnt;
  logic [7:0] last_bank;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign dec_addr  = in_address & AddrMask;
  assign even      = in_value & EvenMask;
  assign dec_cnt   = line_cnt_r - 8'd1;
  assign last_bank = {prg_banks_r[6:0], 1'b0} - 8'd1;

  always_comb begin
    cmd_idx_nxt  = cmd_idx_r;
    armed_nxt    = armed_r;
    line_cnt_nxt = line_cnt_r;
    emit         = 1'b0;
    q_req.op     = OP_ONE;
    q_req.kind   = KIND_NONE;
    q_req.slot   = 3'd0;
    q_req.bank   = 8'd0;
    q_req.pulse  = 1'b0;
    case (action_t'(in_action))
      ACT_WRITE: begin
        case (dec_addr)
          AddrMirror: begin
            emit       = 1'b1;
            q_req.kind = KIND_MIRROR;
            q_req.bank = in_value & LowBit;
          end
          AddrCmd: cmd_idx_nxt = 3'(in_value & CmdMask);
          AddrIrq: begin
            line_cnt_nxt = in_value;
            armed_nxt    = (in_value != 8'd0);
          end
          AddrData: begin
            emit       = 1'b1;
            q_req.kind = KIND_CHR;
            q_req.bank = in_value;
            case (cmd_t'(cmd_idx_r))
              CMD_CHR01: begin
                q_req.op   = OP_PAIR;
                q_req.slot = 3'd0;
                q_req.bank = even;
              end
              CMD_CHR5: q_req.slot = 3'd5;
              CMD_CHR23: begin
                q_req.op   = OP_PAIR;
                q_req.slot = 3'd2;
                q_req.bank = even;
              end
              CMD_CHR7: q_req.slot = 3'd7;
              CMD_PRG0: begin
                q_req.kind = KIND_PRG;
                q_req.slot = 3'd0;
              end
              CMD_PRG1: begin
                q_req.kind = KIND_PRG;
                q_req.slot = 3'd1;
              end
              CMD_CHR4: q_req.slot = 3'd4;
              default:  q_req.slot = 3'd6;
            endcase
          end
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (!in_vblank && armed_r) begin
          line_cnt_nxt = dec_cnt;
          if (dec_cnt == 8'd0) begin
            armed_nxt   = 1'b0;
            emit        = 1'b1;
            q_req.pulse = 1'b1;
          end
        end
      end
      ACT_INIT: begin
        cmd_idx_nxt  = 3'd0;
        armed_nxt    = 1'b0;
        line_cnt_nxt = 8'd0;
        emit         = 1'b1;
        q_req.op     = OP_INIT;
        q_req.kind   = KIND_PRG;
        q_req.bank   = last_bank;
      end
      default: ;
    endcase
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_banks_r <= PrgReset;
      cmd_idx_r   <= 3'd0;
      armed_r     <= 1'b0;
      line_cnt_r  <= 8'd0;
    end else begin
      if (cfg_valid) prg_banks_r <= cfg_data;
      if (accept) begin
        cmd_idx_r  <= cmd_idx_nxt;
        armed_r    <= armed_nxt;
        line_cnt_r <= line_cnt_nxt;
      end
    end
  end

endmodule

// ===== sv/bcm_queue.sv =====
// Short request queue between front and back end, QDepth entries.
// Depends on bcm_pkg for the entry type and depth.
module bcm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bcm_pkg::req_t push_req,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output bcm_pkg::req_t head
);
  import bcm_pkg::*;

  req_t              ent_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r;
  logic [QPtrW-1:0]  rd_ptr_r;
  logic [QPtrW:0]    count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == (QPtrW+1)'(QDepth));
  assign not_empty = (count_r != '0);
  assign head      = ent_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/bcm_back.sv =====
// Back end: expands queued requests into result items, one per cycle while
// out_ready is high, through a registered output stage. Depends on bcm_pkg.
module bcm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  bcm_pkg::req_t q_head,
  output logic          q_pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    out_kind,
  output logic [2:0]    out_slot,
  output logic [7:0]    out_bank,
  output logic          out_pulse,
  output logic          out_last
);
  import bcm_pkg::*;

  logic [3:0] step_r;
  logic       valid_r;
  kind_t      kind_r;
  logic [2:0] slot_r;
  logic [7:0] bank_r;
  logic       pulse_r, last_r;

  kind_t      g_kind;
  logic [2:0] g_slot;
  logic [7:0] g_bank;
  logic       g_last;
  logic       load;

  assign load  = q_valid && (!valid_r || out_ready);
  assign q_pop = load && g_last;

  always_comb begin
    g_kind = q_head.kind;
    g_slot = q_head.slot;
    g_bank = q_head.bank;
    g_last = 1'b1;
    case (q_head.op)
      OP_PAIR: begin
        g_last = (step_r != 4'd0);
        if (step_r != 4'd0) begin
          g_slot = q_head.slot | 3'd1;
          g_bank = q_head.bank | 8'd1;
        end
      end
      OP_INIT: begin
        g_last = (step_r == InitLastStep);
        if (step_r < InitChrStart) begin
          g_kind = KIND_PRG;
          g_slot = step_r[2:0];
          case (step_r[1:0])
            2'd0:    g_bank = 8'd0;
            2'd1:    g_bank = 8'd1;
            2'd2:    g_bank = q_head.bank - 8'd1;
            default: g_bank = q_head.bank;
          endcase
        end else begin
          g_kind = KIND_CHR;
          g_slot = 3'(step_r - InitChrStart);
          g_bank = {5'd0, g_slot};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 4'd0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (load) step_r <= g_last ? 4'd0 : step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= g_kind;
      slot_r  <= g_slot;
      bank_r  <= g_bank;
      pulse_r <= q_head.pulse;
      last_r  <= g_last;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_slot  = slot_r;
  assign out_bank  = bank_r;
  assign out_pulse = pulse_r;
  assign out_last  = last_r;

endmodule

// ===== sv/banked_cartridge_mapper_scanline_irq_top.sv =====
// Banked cartridge mapper with scanline IRQ counter: top level.
// Results pass the queue and a registered output stage. Throughput: one request per
// cycle unless the queue is full; one result per cycle while out_tready is high
// (init gives 12 results). A 4-entry request queue lets input run ahead of the result
// expander. Reset (sync, rst_n low): clears command index, IRQ state, queue and output;
// program size register returns to 2. Depends on bcm_pkg, front, queue, back.
module banked_cartridge_mapper_scanline_irq_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: program ROM size in 16KB units
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // [15:0] address, [23:16] value, [24] in_vblank, rest 0
  input  logic [1:0]  in_tuser,  // [1:0] action
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // [2:0] slot, [10:3] bank, [11] irq_pulse, rest 0
  output logic [1:0]  out_tuser, // [1:0] update_kind
  output logic        out_tlast
);
  import bcm_pkg::*;

  logic       q_push, q_pop, q_full, q_valid;
  req_t       q_req, q_head;
  logic [2:0] res_slot;
  logic [7:0] res_bank;
  logic       res_pulse;

  // The size register is always writable; software must only write it while idle, the block does not enforce this.
  assign cfg_ready = 1'b1;

  // Front end decodes writes, runs the line counter, queues result requests.
  bcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_action  (in_tuser),
    .in_address (in_tdata[15:0]),
    .in_value   (in_tdata[23:16]),
    .in_vblank  (in_tdata[24]),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .q_push     (q_push),
    .q_req      (q_req)
  );

  bcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (q_req),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back end expands pairs and the init sequence into individual results.
  bcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_slot  (res_slot),
    .out_bank  (res_bank),
    .out_pulse (res_pulse),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'd0, res_pulse, res_bank, res_slot};

endmodule

// ===== sv/bcm_checker.sv =====
// Port-level checks for the mapper top level, attached by bind.
// Depends on bcm_pkg and banked_cartridge_mapper_scanline_irq_top.
module bcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import bcm_pkg::*;

  // An IRQ result stands alone: pulse set, last set, no mapping data.
  a_irq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NONE |-> out_tdata[11] && out_tlast
      && out_tdata[10:0] == 11'd0)
    else $error("IRQ result malformed");

  // Pulse only appears on IRQ results.
  a_pulse_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tuser == KIND_NONE)
    else $error("pulse on mapping result");

  // Mirroring is a single result at slot 0 with a one-bit bank.
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_MIRROR |-> out_tlast
      && out_tdata[2:0] == 3'd0 && out_tdata[10:4] == 7'd0)
    else $error("mirroring result malformed");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind banked_cartridge_mapper_scanline_irq_top bcm_checker u_bcm_checker (.*);
